/* rtl/core/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_GROUP_BITS   = 16384;
    localparam int DEF_HEADER_BYTES = 24;

    localparam int POS_W   = 16;   // bitmap position
    localparam int ADDR_W  = 10;   // bitmap word address
    localparam int WORD_W  = 64;
    localparam int WORDS   = 1024;
    localparam int CMD_W   = 3;
    localparam int RUN_W   = 17;
    localparam int CNT_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 152;

    localparam logic [CMD_W-1:0] CMD_FREE        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_RANGE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC_GOAL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ        = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NO_BITMAP  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PART_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITMAP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACKING   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_FREE  = 2'd3;

    localparam logic [POS_W-1:0] RST_PART_LEN = 16'd65344;

    typedef struct packed {
        logic [POS_W-1:0] part_len;
        logic             bitmap_present;
        logic             count_tracking;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  start_block;
        logic [POS_W-1:0]  start_offset;
        logic [RUN_W-1:0]  run_length;
        logic [POS_W-1:0]  target_block;
        logic [ADDR_W-1:0] word_index;
        logic [WORD_W-1:0] word_value;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [POS_W-1:0]  allocated_block;
        logic [RUN_W-1:0]  blocks_done;
        logic [RUN_W-1:0]  already_free;
        logic [CNT_W-1:0]  free_blocks;
        logic [WORD_W-1:0] read_value;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

/* rtl/core/bba_mem.sv */
// ----------------------------------------------------------------------------
// bba_mem
// Space bitmap store, 1024 x 64, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_mem (
    input  logic                          i_clk,
    input  bba_pkg::t_mem_req             i_req,
    output logic [bba_pkg::WORD_W-1:0]    o_rdata
);
    import bba_pkg::*;

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bba_seq.sv */
// ----------------------------------------------------------------------------
// bba_seq
// Command sequencer: word write/read and bit-at-a-time read/modify/write over the bitmap store,
// with a shared subtract-loop divider and byte/bit scan routines.
// ----------------------------------------------------------------------------
module bba_seq #(
    parameter int GROUP_BITS   = bba_pkg::DEF_GROUP_BITS,
    parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bba_pkg::t_cfg                  i_cfg,
    input  logic                           i_fc_load,
    input  logic [bba_pkg::CNT_W-1:0]      i_fc_value,
    input  logic                           i_start,
    input  logic [bba_pkg::CMD_W-1:0]      i_cmd,
    input  bba_pkg::t_item                 i_item,
    output logic                           o_ready,
    output logic                           o_res_valid,
    output bba_pkg::t_result               o_res,
    input  logic                           i_out_free,
    output bba_pkg::t_mem_req              o_mem_req,
    input  logic [bba_pkg::WORD_W-1:0]     i_mem_rdata
);
    import bba_pkg::*;

    localparam int HDR_BITS    = HEADER_BYTES * 8;
    localparam int GROUP_BYTES = GROUP_BITS / 8;
    localparam int B_W   = $clog2(GROUP_BITS + 1);
    localparam int K_W   = $clog2(GROUP_BYTES + 1);
    localparam int REM_W = $clog2(65536 + HDR_BITS + GROUP_BITS);
    localparam int G_W   = $clog2((65536 + HDR_BITS + GROUP_BITS) / GROUP_BITS + 1);
    localparam int I_W   = G_W + 1;

    localparam logic [B_W-1:0]   GB_B   = B_W'(GROUP_BITS);
    localparam logic [REM_W-1:0] GB_R   = REM_W'(GROUP_BITS);
    localparam logic [K_W-1:0]   GBY_K  = K_W'(GROUP_BYTES);
    localparam logic [REM_W-1:0] HDR_R  = REM_W'(HDR_BITS);
    localparam logic [POS_W-1:0] HDR_P  = POS_W'(HDR_BITS);
    localparam logic [K_W-1:0]   HB_K   = K_W'(HEADER_BYTES);
    localparam logic [B_W-1:0]   HDRB_B = B_W'(HDR_BITS);

    typedef enum logic [27:0] {
        S_CLR    = 28'b1 << 0,
        S_IDLE   = 28'b1 << 1,
        S_DISP   = 28'b1 << 2,
        S_FREE_RD= 28'b1 << 3,
        S_FREE_OP= 28'b1 << 4,
        S_DIV    = 28'b1 << 5,
        S_NR     = 28'b1 << 6,
        S_AR_CHK = 28'b1 << 7,
        S_AR_RD  = 28'b1 << 8,
        S_AR_OP  = 28'b1 << 9,
        S_AR_END = 28'b1 << 10,
        S_GT_RD  = 28'b1 << 11,
        S_GT_OP  = 28'b1 << 12,
        S_SB_CHK = 28'b1 << 13,
        S_SB_RD  = 28'b1 << 14,
        S_SB_OP  = 28'b1 << 15,
        S_SB_RET = 28'b1 << 16,
        S_FO_CHK = 28'b1 << 17,
        S_FO_RD  = 28'b1 << 18,
        S_FO_OP  = 28'b1 << 19,
        S_FO_RET = 28'b1 << 20,
        S_OTH    = 28'b1 << 21,
        S_BK_CHK = 28'b1 << 22,
        S_BK_RD  = 28'b1 << 23,
        S_BK_OP  = 28'b1 << 24,
        S_CL_RD  = 28'b1 << 25,
        S_CLAIM  = 28'b1 << 26,
        S_DONE   = 28'b1 << 27
    } t_state;

    typedef enum logic [2:0] {
        RET_SB_FIRST,
        RET_SB_EG,
        RET_SB_OTHER,
        RET_FO_EG,
        RET_FO_REST,
        RET_FO_OTHER
    } t_ret;

    t_state             r_state;
    t_ret               r_ret;
    logic [ADDR_W-1:0]  r_clr;
    logic [CNT_W-1:0]   r_fc;
    logic [CMD_W-1:0]   r_cmd;
    logic [POS_W-1:0]   r_start;
    logic [POS_W-1:0]   r_offs;
    logic [RUN_W-1:0]   r_run;
    logic [POS_W-1:0]   r_goal;
    logic [ADDR_W-1:0]  r_widx;
    logic [WORD_W-1:0]  r_wval;
    logic [STAT_W-1:0]  r_status;
    logic [POS_W-1:0]   r_blk;
    logic [RUN_W-1:0]   r_done;
    logic [RUN_W-1:0]   r_already;
    logic [POS_W-1:0]   r_p;
    logic [RUN_W-1:0]   r_cnt;
    logic [REM_W-1:0]   r_rem;
    logic [G_W-1:0]     r_quo;
    logic [G_W-1:0]     r_g;
    logic [G_W-1:0]     r_nr;
    logic [B_W-1:0]     r_b;
    logic [B_W-1:0]     r_lim;
    logic [K_W-1:0]     r_k;
    logic [2:0]         r_j;
    logic [I_W-1:0]     r_i;
    logic               r_hit;

    logic [POS_W-1:0]   w_pos;
    logic               w_bit;
    logic [WORD_W-1:0]  w_mask;
    logic [B_W-1:0]     w_gs_bits;
    logic [K_W-1:0]     w_gs_k;
    logic [G_W-1:0]     w_gn;
    logic               w_gn_zero;
    logic [B_W:0]       w_eg_raw;
    logic [B_W-1:0]     w_eg;

    function automatic logic [POS_W-1:0] gpos(input logic [G_W-1:0] g,
                                              input logic [B_W-1:0] b);
        return POS_W'(32'(g) * 32'(GROUP_BITS) + 32'(b));
    endfunction

    always_comb begin
        unique case (r_state)
            S_FREE_RD, S_FREE_OP: w_pos = r_p + r_cnt[POS_W-1:0];
            S_SB_RD, S_SB_OP:     w_pos = gpos(r_g, B_W'({r_k, 3'b000}) + B_W'(r_j));
            S_BK_RD, S_BK_OP:     w_pos = gpos(r_g, r_b - B_W'(1));
            default:              w_pos = gpos(r_g, r_b);
        endcase
    end

    assign w_bit     = i_mem_rdata[w_pos[5:0]];
    assign w_mask    = WORD_W'(1) << w_pos[5:0];
    assign w_gs_bits = (r_g == '0) ? HDRB_B : '0;
    assign w_gs_k    = (r_g == '0) ? HB_K : '0;
    assign w_gn      = (({1'b0, r_g} + (G_W+1)'(1)) >= {1'b0, r_nr}) ? '0 : r_g + G_W'(1);
    assign w_gn_zero = (w_gn == '0);
    // next 64-bit boundary, clipped to the group end
    assign w_eg_raw  = ({1'b0, r_b} + (B_W+1)'(63)) & {{(B_W-5){1'b1}}, 6'b000000};
    assign w_eg      = (w_eg_raw > {1'b0, GB_B}) ? GB_B : w_eg_raw[B_W-1:0];

    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = w_pos[POS_W-1:6];
        o_mem_req.wdata = i_mem_rdata;
        o_mem_req.re    = 1'b0;
        o_mem_req.raddr = w_pos[POS_W-1:6];
        unique case (r_state)
            S_CLR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr;
                o_mem_req.wdata = '0;
            end
            S_DISP: begin
                if (r_cmd == CMD_WRITE) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_widx;
                    o_mem_req.wdata = r_wval;
                end else if (r_cmd == CMD_READ) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_widx;
                end
            end
            S_FREE_RD, S_AR_RD, S_GT_RD, S_SB_RD, S_FO_RD, S_BK_RD, S_CL_RD: begin
                o_mem_req.re = 1'b1;
            end
            S_FREE_OP: begin
                o_mem_req.we    = !w_bit;
                o_mem_req.wdata = i_mem_rdata | w_mask;
            end
            S_AR_OP: begin
                o_mem_req.we    = w_bit;
                o_mem_req.wdata = i_mem_rdata & ~w_mask;
            end
            S_CLAIM: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = i_mem_rdata & ~w_mask;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_fc    <= '0;
        end else begin
            if (i_fc_load) begin
                r_fc <= i_fc_value;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + ADDR_W'(1);
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cmd   <= i_cmd;
                        r_start <= i_item.start_block;
                        r_offs  <= i_item.start_offset;
                        r_run   <= i_item.run_length;
                        r_goal  <= i_item.target_block;
                        r_widx  <= i_item.word_index;
                        r_wval  <= i_item.word_value;
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_status  <= STAT_OK;
                    r_blk     <= '0;
                    r_done    <= '0;
                    r_already <= '0;
                    r_state   <= S_DONE;
                    case (r_cmd)
                        CMD_FREE: begin
                            if (!i_cfg.bitmap_present) begin
                                r_status <= STAT_NO_BITMAP;
                            end else if ((18'(r_start) + 18'(r_run)) > 18'(i_cfg.part_len)) begin
                                r_status <= STAT_RANGE;
                            end else begin
                                r_p   <= r_start + r_offs + HDR_P;
                                r_cnt <= '0;
                                if (r_run != '0) begin
                                    r_state <= S_FREE_RD;
                                end
                            end
                        end
                        CMD_ALLOC_RANGE: begin
                            if (r_start >= i_cfg.part_len) begin
                                r_status <= STAT_RANGE;
                            end else begin
                                r_rem   <= REM_W'(r_start) + HDR_R;
                                r_quo   <= '0;
                                r_state <= S_DIV;
                            end
                        end
                        CMD_ALLOC_GOAL: begin
                            // goal outside the partition falls back to block 0
                            r_rem   <= REM_W'((r_goal >= i_cfg.part_len) ? '0 : r_goal) + HDR_R;
                            r_quo   <= '0;
                            r_state <= S_DIV;
                        end
                        default: begin
                        end
                    endcase
                end
                S_FREE_RD: r_state <= S_FREE_OP;
                S_FREE_OP: begin
                    if (w_bit) begin
                        r_already <= r_already + RUN_W'(1);
                    end else begin
                        r_done <= r_done + RUN_W'(1);
                        if (i_cfg.count_tracking) begin
                            r_fc <= r_fc + CNT_W'(1);
                        end
                    end
                    r_cnt   <= r_cnt + RUN_W'(1);
                    r_state <= ((r_cnt + RUN_W'(1)) == r_run) ? S_DONE : S_FREE_RD;
                end
                S_DIV: begin
                    if (r_rem >= GB_R) begin
                        r_rem <= r_rem - GB_R;
                        r_quo <= r_quo + G_W'(1);
                    end else begin
                        r_g <= r_quo;
                        r_b <= B_W'(r_rem);
                        if (r_cmd == CMD_ALLOC_RANGE) begin
                            r_state <= S_AR_CHK;
                        end else begin
                            // group count, rounded up
                            r_rem   <= REM_W'(i_cfg.part_len) + HDR_R + GB_R - REM_W'(1);
                            r_quo   <= '0;
                            r_state <= S_NR;
                        end
                    end
                end
                S_NR: begin
                    if (r_rem >= GB_R) begin
                        r_rem <= r_rem - GB_R;
                        r_quo <= r_quo + G_W'(1);
                    end else begin
                        r_nr    <= r_quo;
                        r_k     <= w_gs_k;
                        r_j     <= '0;
                        r_ret   <= RET_SB_FIRST;
                        r_state <= S_SB_CHK;
                    end
                end
                S_AR_CHK: begin
                    r_state <= (r_b >= GB_B || r_run == '0) ? S_AR_END : S_AR_RD;
                end
                S_AR_RD: r_state <= S_AR_OP;
                S_AR_OP: begin
                    if (!w_bit) begin
                        r_state <= S_AR_END;
                    end else begin
                        r_run   <= r_run - RUN_W'(1);
                        r_done  <= r_done + RUN_W'(1);
                        r_b     <= r_b + B_W'(1);
                        r_state <= S_AR_CHK;
                    end
                end
                S_AR_END: begin
                    if (i_cfg.count_tracking) begin
                        r_fc <= r_fc - CNT_W'(r_done);
                    end
                    r_state <= S_DONE;
                end
                S_GT_RD: r_state <= S_GT_OP;
                S_GT_OP: begin
                    if (w_bit) begin
                        r_state <= S_CL_RD;
                    end else begin
                        r_lim   <= w_eg;
                        r_ret   <= RET_FO_EG;
                        r_state <= S_FO_CHK;
                    end
                end
                S_SB_CHK: begin
                    if (r_k >= GBY_K) begin
                        r_hit   <= 1'b0;
                        r_state <= S_SB_RET;
                    end else begin
                        r_state <= S_SB_RD;
                    end
                end
                S_SB_RD: r_state <= S_SB_OP;
                S_SB_OP: begin
                    if (!w_bit) begin
                        r_k     <= r_k + K_W'(1);
                        r_j     <= '0;
                        r_state <= S_SB_CHK;
                    end else if (r_j == 3'd7) begin
                        r_hit   <= 1'b1;
                        r_state <= S_SB_RET;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_SB_RD;
                    end
                end
                S_SB_RET: begin
                    case (r_ret)
                        RET_SB_FIRST: begin
                            if (r_hit) begin
                                r_state <= S_GT_RD;
                            end else begin
                                r_i     <= '0;
                                r_state <= S_OTH;
                            end
                        end
                        RET_SB_EG: begin
                            if (r_hit) begin
                                r_b     <= B_W'({r_k, 3'b000});
                                r_j     <= '0;
                                r_state <= S_BK_CHK;
                            end else begin
                                r_lim   <= GB_B;
                                r_ret   <= RET_FO_REST;
                                r_state <= S_FO_CHK;
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                r_b     <= B_W'({r_k, 3'b000});
                                r_j     <= '0;
                                r_state <= S_BK_CHK;
                            end else begin
                                r_i     <= r_i + I_W'(1);
                                r_state <= S_OTH;
                            end
                        end
                    endcase
                end
                S_FO_CHK: begin
                    if (r_b >= r_lim) begin
                        r_hit   <= 1'b0;
                        r_state <= S_FO_RET;
                    end else begin
                        r_state <= S_FO_RD;
                    end
                end
                S_FO_RD: r_state <= S_FO_OP;
                S_FO_OP: begin
                    if (w_bit) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FO_RET;
                    end else begin
                        r_b     <= r_b + B_W'(1);
                        r_state <= S_FO_CHK;
                    end
                end
                S_FO_RET: begin
                    case (r_ret)
                        RET_FO_EG: begin
                            if (r_hit) begin
                                r_state <= S_CL_RD;
                            end else begin
                                // r_b sits on the boundary: look for a whole free byte
                                r_k     <= K_W'(r_b >> 3);
                                r_j     <= '0;
                                r_ret   <= RET_SB_EG;
                                r_state <= S_SB_CHK;
                            end
                        end
                        RET_FO_REST: begin
                            if (r_hit) begin
                                r_state <= S_CL_RD;
                            end else begin
                                r_i     <= '0;
                                r_state <= S_OTH;
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                r_j     <= '0;
                                r_state <= S_BK_CHK;
                            end else begin
                                r_i     <= r_i + I_W'(1);
                                r_state <= S_OTH;
                            end
                        end
                    endcase
                end
                S_OTH: begin
                    // first lap over the groups wants a free byte, second lap any bit
                    if (r_i >= {r_nr, 1'b0}) begin
                        r_status <= STAT_NO_SPACE;
                        r_state  <= S_DONE;
                    end else begin
                        r_g <= w_gn;
                        if (r_i < I_W'(r_nr)) begin
                            r_k     <= w_gn_zero ? HB_K : '0;
                            r_j     <= '0;
                            r_ret   <= RET_SB_OTHER;
                            r_state <= S_SB_CHK;
                        end else begin
                            r_b     <= w_gn_zero ? HDRB_B : '0;
                            r_lim   <= GB_B;
                            r_ret   <= RET_FO_OTHER;
                            r_state <= S_FO_CHK;
                        end
                    end
                end
                S_BK_CHK: begin
                    r_state <= (r_j < 3'd7 && r_b > w_gs_bits) ? S_BK_RD : S_CL_RD;
                end
                S_BK_RD: r_state <= S_BK_OP;
                S_BK_OP: begin
                    if (w_bit) begin
                        r_b     <= r_b - B_W'(1);
                        r_j     <= r_j + 3'd1;
                        r_state <= S_BK_CHK;
                    end else begin
                        r_state <= S_CL_RD;
                    end
                end
                S_CL_RD: r_state <= S_CLAIM;
                S_CLAIM: begin
                    if (i_cfg.count_tracking) begin
                        r_fc <= r_fc - CNT_W'(1);
                    end
                    r_blk   <= w_pos - HDR_P;
                    r_done  <= RUN_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status          = r_status;
        o_res.allocated_block = r_blk;
        o_res.blocks_done     = r_done;
        o_res.already_free    = r_already;
        o_res.free_blocks     = r_fc;
        o_res.read_value      = (r_cmd == CMD_READ) ? i_mem_rdata : '0;
    end

    a_no_start_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_start)
        else $error("item started during clearing pass");

    a_free_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FREE_OP) |-> (r_cnt == r_done + r_already))
        else $error("free run counters out of step");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FO_CHK) |-> (r_b <= r_lim))
        else $error("bit scan passed its limit");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_out_free) |=> (r_state == S_IDLE))
        else $error("result handed over but sequencer not idle");

endmodule

/* rtl/core/bitmap_block_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Free-space bitmap block allocator: free, range and goal allocation,
// direct word access, free block counter.
// ----------------------------------------------------------------------------
// Usage: commands enter on the s_axis channel (tuser = command, tdata = the
// operands), one result per command leaves on m_axis. Configuration is a
// plain write port; the user must write it only while the block is idle,
// as the block does not enforce this. Writing the initial free count also
// loads the free counter. After reset a clearing pass zeroes the bitmap
// with tready low; the registers take their reset values at once.
// One command at a time. Each bitmap bit touched is read, then modified,
// over the single memory port, after a dispatch step; word write and read
// need only that step. Range and goal allocation first divide the position
// by repeated subtraction (one subtract per group). Goal allocation walks
// bytes, then bits.
// The result sits in an output register; the next command is accepted
// while it waits, and finishes only once the receiver has taken it.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int GROUP_BITS   = bba_pkg::DEF_GROUP_BITS,
    parameter int HEADER_BYTES = bba_pkg::DEF_HEADER_BYTES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // start_block, start_offset, run_length, target_block, word_index, word_value
    input  logic [bba_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic [bba_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status, allocated_block, blocks_done, already_free, free_blocks, read_value
    output logic [bba_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import bba_pkg::*;

    t_cfg              r_cfg;
    logic              r_ovld;
    t_result           r_ores;
    t_item             w_item;
    t_result           w_res;
    t_mem_req          w_mem_req;
    logic [WORD_W-1:0] w_mem_rdata;
    logic              w_ready;
    logic              w_res_valid;
    logic              w_out_free;
    logic              w_fc_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.part_len       <= RST_PART_LEN;
            r_cfg.bitmap_present <= 1'b1;
            r_cfg.count_tracking <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PART_LEN: r_cfg.part_len       <= i_cfg_data[POS_W-1:0];
                CFG_BITMAP:   r_cfg.bitmap_present <= i_cfg_data[0];
                CFG_TRACKING: r_cfg.count_tracking <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_fc_load = i_cfg_we && (i_cfg_idx == CFG_INIT_FREE);

    assign w_item.start_block  = s_axis_tdata[15:0];
    assign w_item.start_offset = s_axis_tdata[31:16];
    assign w_item.run_length   = s_axis_tdata[48:32];
    assign w_item.target_block = s_axis_tdata[64:49];
    assign w_item.word_index   = s_axis_tdata[74:65];
    assign w_item.word_value   = s_axis_tdata[138:75];

    assign w_out_free = !r_ovld || m_axis_tready;

    bba_seq #(
        .GROUP_BITS   (GROUP_BITS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_fc_load   (w_fc_load),
        .i_fc_value  (i_cfg_data),
        .i_start     (s_axis_tvalid && w_ready),
        .i_cmd       (s_axis_tuser),
        .i_item      (w_item),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_out_free  (w_out_free),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata)
    );

    bba_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_res_valid && w_out_free) begin
            r_ovld <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_out_free) begin
            r_ores <= w_res;
        end
    end

    assign s_axis_tready = w_ready;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {4'b0000, r_ores.read_value, r_ores.free_blocks,
                            r_ores.already_free, r_ores.blocks_done,
                            r_ores.allocated_block, r_ores.status};

endmodule
